@@ rtl/gjps_pkg.sv @@
// ----------------------------------------------------------------------------
// gjps_pkg
// Shared types, codes and helpers for the 8-direction jump unit.
// ----------------------------------------------------------------------------
package gjps_pkg;

  localparam int GRID_DIM_DEF = 64;

  typedef logic signed [8:0] coord_t;
  typedef logic signed [1:0] sdir_t;

  localparam logic [2:0] REG_ALLOW_SQUEEZE = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_GRID_WIDTH    = 3'd2;
  localparam logic [2:0] REG_GOAL_ROW      = 3'd3;
  localparam logic [2:0] REG_GOAL_COL      = 3'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [3:0] DIR_UP         = 4'd1;
  localparam logic [3:0] DIR_UP_RIGHT   = 4'd2;
  localparam logic [3:0] DIR_RIGHT      = 4'd3;
  localparam logic [3:0] DIR_DOWN_RIGHT = 4'd4;
  localparam logic [3:0] DIR_DOWN       = 4'd5;
  localparam logic [3:0] DIR_DOWN_LEFT  = 4'd6;
  localparam logic [3:0] DIR_LEFT       = 4'd7;
  localparam logic [3:0] DIR_UP_LEFT    = 4'd8;

  function automatic sdir_t dir_row(input logic [3:0] d);
    sdir_t r;
    unique case (d)
      DIR_UP, DIR_UP_RIGHT, DIR_UP_LEFT:          r = -2'sd1;
      DIR_DOWN_RIGHT, DIR_DOWN, DIR_DOWN_LEFT:    r = 2'sd1;
      default:                                    r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic sdir_t dir_col(input logic [3:0] d);
    sdir_t c;
    unique case (d)
      DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT:    c = 2'sd1;
      DIR_DOWN_LEFT, DIR_LEFT, DIR_UP_LEFT:       c = -2'sd1;
      default:                                    c = 2'sd0;
    endcase
    return c;
  endfunction

  // 3x3 neighbourhood lookup, offsets -1..1
  function automatic logic win_at(input logic [8:0] w, input sdir_t dr, input sdir_t dc);
    logic [3:0] idx;
    idx = 4'(3 * (int'(dr) + 1) + int'(dc) + 1);
    return w[idx];
  endfunction

endpackage

@@ rtl/grid_jump_point_search_8dir.sv @@
// ----------------------------------------------------------------------------
// grid_jump_point_search_8dir
// Jump unit for 8-connected jump point search over a row-wide obstacle RAM.
//
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | tuser kind, tdata cell, direction, bit
//  out_    | out | tvalid/tready      | tdata stop cell and found flag
//  cfg_    | in  | cfg_valid/ready    | register index and write data
//
// After reset a clearing pass zeroes every RAM row; no input item is taken.
// A write is a read-modify-write of one RAM row.
// A query passes a fetch state (row check) and an evaluate state per cell visited,
// plus load states LD0..LD3 for the three RAM rows around a cell whenever the walk
// changes row; diagonal walks add both straight sub-walks at every diagonal cell.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module grid_jump_point_search_8dir
  import gjps_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // query_row[5:0], query_col[11:6], step_direction[15:12],
                                  // blocked[16], zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // stop_row[7:0], stop_col[15:8], found[16], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int AW = $clog2(GRID_DIM);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_WR_RD, ST_WR_WB, ST_FETCH,
    ST_LD0, ST_LD1, ST_LD2, ST_LD3, ST_EVAL, ST_DONE
  } state_t;

  state_t state_r;

  logic [GRID_DIM-1:0] mem [GRID_DIM];
  logic [GRID_DIM-1:0] rd_data_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [GRID_DIM-1:0] mem_wd;

  logic       allow_sq_r;
  logic [6:0] grid_h_r, grid_w_r;
  logic [5:0] goal_row_r, goal_col_r;

  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] wr_row_r, wr_col_r;
  logic          wr_blk_r;

  coord_t cr_r, cc_r, mi_r, mj_r;
  sdir_t  di_r, dj_r, cdi_r, cdj_r;
  logic   sub_r, phase_r, sq_r;
  logic   ld_ok_r;
  logic [2:0][GRID_DIM-1:0] rows_r;
  logic   cache_vld_r;
  coord_t cache_row_r;

  coord_t res_row_r, res_col_r;
  logic   res_found_r;
  logic   out_valid_r;
  logic [7:0] out_row_r, out_col_r;
  logic   out_found_r;
  logic   out_load;

  logic [6:0] used_rows, used_cols;
  logic [5:0] q_row, q_col;
  logic [3:0] q_dir;
  logic       q_blk;
  logic       in_xfer;

  assign q_row   = in_tdata[5:0];
  assign q_col   = in_tdata[11:6];
  assign q_dir   = in_tdata[15:12];
  assign q_blk   = in_tdata[16];
  assign in_xfer = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_found_r, out_col_r, out_row_r};
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign used_rows = (11'(grid_h_r) > 11'(GRID_DIM)) ? 7'(GRID_DIM) : grid_h_r;
  assign used_cols = (11'(grid_w_r) > 11'(GRID_DIM)) ? 7'(GRID_DIM) : grid_w_r;

  function automatic logic row_on(input coord_t x, input logic [6:0] lim);
    return !x[8] && (x < coord_t'({2'b00, lim}));
  endfunction

  // load row address
  coord_t ld_row;
  logic   ld_ok;
  always_comb begin
    unique case (state_r)
      ST_LD0:  ld_row = cr_r - coord_t'(1);
      ST_LD2:  ld_row = cr_r + coord_t'(1);
      default: ld_row = cr_r;
    endcase
    ld_ok = row_on(ld_row, used_rows);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_row_r;
    mem_wd = rd_data_r;
    mem_re = 1'b0;
    mem_ra = AW'($unsigned(ld_row));
    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      ST_WR_RD: begin
        mem_re = 1'b1;
        mem_ra = wr_row_r;
      end
      ST_WR_WB: begin
        mem_we = 1'b1;
        mem_wd[wr_col_r] = wr_blk_r;
      end
      ST_LD0, ST_LD1, ST_LD2: mem_re = ld_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // 3x3 window around the current cell
  logic [8:0] w_on, w_obs, w_free;
  always_comb begin
    coord_t rr, col;
    logic   on, bit_v;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        rr    = cr_r + coord_t'(dr - 1);
        col   = cc_r + coord_t'(dc - 1);
        on    = row_on(rr, used_rows) && row_on(col, used_cols);
        bit_v = on ? rows_r[dr][AW'($unsigned(col))] : 1'b0;
        w_on[dr*3+dc]   = on;
        w_obs[dr*3+dc]  = on && bit_v;
        w_free[dr*3+dc] = on && !bit_v;
      end
    end
  end

  logic   here_stop, here_goal, here_forced, here_sq;
  sdir_t  pi, pj;
  always_comb begin
    pi = cdj_r[1] ? -cdj_r : cdj_r;
    pj = cdi_r[1] ? -cdi_r : cdi_r;
    here_stop = !w_on[4] || w_obs[4];
    here_goal = (cr_r == coord_t'({3'b000, goal_row_r})) &&
                (cc_r == coord_t'({3'b000, goal_col_r}));
    if (cdi_r == 2'sd0 || cdj_r == 2'sd0) begin
      here_forced = !(!allow_sq_r && win_at(w_obs, cdi_r, cdj_r)) &&
        ((win_at(w_obs, pi, pj) && win_at(w_free, pi + cdi_r, pj + cdj_r)) ||
         (win_at(w_obs, -pi, -pj) && win_at(w_free, -pi + cdi_r, -pj + cdj_r)));
    end else begin
      here_forced =
        (win_at(w_obs, -cdi_r, 2'sd0) && win_at(w_free, -cdi_r, cdj_r) &&
         !(!allow_sq_r && win_at(w_obs, 2'sd0, cdj_r))) ||
        (win_at(w_obs, 2'sd0, -cdj_r) && win_at(w_free, cdi_r, -cdj_r) &&
         !(!allow_sq_r && win_at(w_obs, cdi_r, 2'sd0)));
    end
    here_sq = win_at(w_on, cdi_r, cdj_r) && win_at(w_obs, 2'sd0, cdj_r) &&
              win_at(w_obs, cdi_r, 2'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      allow_sq_r  <= 1'b0;
      grid_h_r    <= 7'd64;
      grid_w_r    <= 7'd64;
      goal_row_r  <= '0;
      goal_col_r  <= '0;
      out_valid_r <= 1'b0;
      cache_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ALLOW_SQUEEZE: allow_sq_r <= cfg_data[0];
          REG_GRID_HEIGHT:   grid_h_r   <= cfg_data;
          REG_GRID_WIDTH:    grid_w_r   <= cfg_data;
          REG_GOAL_ROW:      goal_row_r <= cfg_data[5:0];
          REG_GOAL_COL:      goal_col_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(GRID_DIM - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            cache_vld_r <= 1'b0;
            if (in_tuser == KIND_WRITE) begin
              wr_row_r <= AW'(q_row);
              wr_col_r <= AW'(q_col);
              wr_blk_r <= q_blk;
              if (11'(q_row) < 11'(GRID_DIM) && 11'(q_col) < 11'(GRID_DIM)) begin
                state_r <= ST_WR_RD;
              end
            end else begin
              di_r    <= dir_row(q_dir);
              dj_r    <= dir_col(q_dir);
              cdi_r   <= dir_row(q_dir);
              cdj_r   <= dir_col(q_dir);
              sub_r   <= 1'b0;
              mi_r    <= coord_t'({3'b000, q_row});
              mj_r    <= coord_t'({3'b000, q_col});
              cr_r    <= coord_t'({3'b000, q_row}) + coord_t'(dir_row(q_dir));
              cc_r    <= coord_t'({3'b000, q_col}) + coord_t'(dir_col(q_dir));
              if (dir_row(q_dir) == 2'sd0 && dir_col(q_dir) == 2'sd0) begin
                res_row_r   <= coord_t'({3'b000, q_row});
                res_col_r   <= coord_t'({3'b000, q_col});
                res_found_r <= 1'b0;
                state_r     <= ST_DONE;
              end else begin
                state_r <= ST_FETCH;
              end
            end
          end
        end
        ST_WR_RD: state_r <= ST_WR_WB;
        ST_WR_WB: state_r <= ST_IDLE;
        ST_FETCH: begin
          if (cache_vld_r && cache_row_r == cr_r) begin
            state_r <= ST_EVAL;
          end else begin
            state_r <= ST_LD0;
          end
        end
        ST_LD0: begin
          ld_ok_r <= ld_ok;
          state_r <= ST_LD1;
        end
        ST_LD1: begin
          rows_r[0] <= ld_ok_r ? rd_data_r : '0;
          ld_ok_r   <= ld_ok;
          state_r   <= ST_LD2;
        end
        ST_LD2: begin
          rows_r[1] <= ld_ok_r ? rd_data_r : '0;
          ld_ok_r   <= ld_ok;
          state_r   <= ST_LD3;
        end
        ST_LD3: begin
          rows_r[2]   <= ld_ok_r ? rd_data_r : '0;
          cache_vld_r <= 1'b1;
          cache_row_r <= cr_r;
          state_r     <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!sub_r) begin
            priority if (here_stop) begin
              res_row_r   <= cr_r;
              res_col_r   <= cc_r;
              res_found_r <= 1'b0;
              state_r     <= ST_DONE;
            end else if (here_goal || here_forced) begin
              res_row_r   <= cr_r;
              res_col_r   <= cc_r;
              res_found_r <= 1'b1;
              state_r     <= ST_DONE;
            end else if (di_r == 2'sd0 || dj_r == 2'sd0) begin
              cr_r    <= cr_r + coord_t'(di_r);
              cc_r    <= cc_r + coord_t'(dj_r);
              state_r <= ST_FETCH;
            end else begin
              sq_r    <= here_sq;
              mi_r    <= cr_r;
              mj_r    <= cc_r;
              sub_r   <= 1'b1;
              phase_r <= 1'b0;
              cdi_r   <= di_r;
              cdj_r   <= 2'sd0;
              cr_r    <= cr_r + coord_t'(di_r);
              state_r <= ST_FETCH;
            end
          end else begin
            priority if (here_stop) begin
              if (!phase_r) begin
                phase_r <= 1'b1;
                cdi_r   <= 2'sd0;
                cdj_r   <= dj_r;
                cr_r    <= mi_r;
                cc_r    <= mj_r + coord_t'(dj_r);
                state_r <= ST_FETCH;
              end else if (sq_r) begin
                res_row_r   <= mi_r;
                res_col_r   <= mj_r;
                res_found_r <= 1'b0;
                state_r     <= ST_DONE;
              end else begin
                sub_r   <= 1'b0;
                cdi_r   <= di_r;
                cdj_r   <= dj_r;
                cr_r    <= mi_r + coord_t'(di_r);
                cc_r    <= mj_r + coord_t'(dj_r);
                state_r <= ST_FETCH;
              end
            end else if (here_goal || here_forced) begin
              res_row_r   <= mi_r;
              res_col_r   <= mj_r;
              res_found_r <= 1'b1;
              state_r     <= ST_DONE;
            end else begin
              cr_r    <= cr_r + coord_t'(cdi_r);
              cc_r    <= cc_r + coord_t'(cdj_r);
              state_r <= ST_FETCH;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_row_r   <= res_row_r[7:0];
            out_col_r   <= res_col_r[7:0];
            out_found_r <= res_found_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/grid_jump_point_search_8dir_test.sv @@
// ----------------------------------------------------------------------------
// grid_jump_point_search_8dir_test
// Self-checking bench for the 8-direction jump unit. Obstacle writes and jump
// queries are streamed in, a local predictor of the jump walk produces the
// expected stop cell for every query, and each result transfer is checked
// against the oldest expectation. Directed cases come first, then random
// grids that are mostly small, under varying register settings and back
// pressure on both sides.
// ----------------------------------------------------------------------------
module grid_jump_point_search_8dir_test
  import gjps_pkg::*;
();

  localparam logic [3:0] DIR_STATIC = 4'd0;
  localparam logic [3:0] DIR_BAD_LO = 4'd9;
  localparam logic [3:0] DIR_BAD_HI = 4'd15;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       found;
  } stop_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_data;

  grid_jump_point_search_8dir uut (.*);

  bit          cells [0:63][0:63];
  bit          squeeze_ok;
  int          rows_cfg, cols_cfg, goal_r, goal_c;
  stop_t       exp_ring [0:4095];
  logic [11:0] exp_wr, exp_rd;
  int          errors;
  int          snd_idle, rcv_idle;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int rows_used();
    return rows_cfg > 64 ? 64 : rows_cfg;
  endfunction

  function automatic int cols_used();
    return cols_cfg > 64 ? 64 : cols_cfg;
  endfunction

  function automatic bit on_g(int r, int c);
    return r >= 0 && c >= 0 && r < rows_used() && c < cols_used();
  endfunction

  function automatic bit obst(int r, int c);
    return on_g(r, c) && cells[r][c];
  endfunction

  function automatic bit open_cell(int r, int c);
    return on_g(r, c) && !cells[r][c];
  endfunction

  function automatic bit has_forced(int i, int j, int di, int dj);
    int pi, pj;
    if (di == 0 || dj == 0) begin
      pi = dj < 0 ? -dj : dj;
      pj = di < 0 ? -di : di;
      if (!squeeze_ok && obst(i + di, j + dj)) return 1'b0;
      return (obst(i + pi, j + pj) && open_cell(i + pi + di, j + pj + dj)) ||
             (obst(i - pi, j - pj) && open_cell(i - pi + di, j - pj + dj));
    end
    return (obst(i - di, j) && open_cell(i - di, j + dj) &&
            !(!squeeze_ok && obst(i, j + dj))) ||
           (obst(i, j - dj) && open_cell(i + di, j - dj) &&
            !(!squeeze_ok && obst(i + di, j)));
  endfunction

  function automatic bit walk_line(int i, int j, int di, int dj, output int si, output int sj);
    while (1) begin
      i += di;
      j += dj;
      si = i;
      sj = j;
      if (!on_g(i, j) || obst(i, j)) return 1'b0;
      if ((i == goal_r && j == goal_c) || has_forced(i, j, di, dj)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit walk_diag(int i, int j, int di, int dj, output int si, output int sj);
    int ti, tj;
    while (1) begin
      i += di;
      j += dj;
      si = i;
      sj = j;
      if (!on_g(i, j) || obst(i, j)) return 1'b0;
      if ((i == goal_r && j == goal_c) || has_forced(i, j, di, dj)) return 1'b1;
      if (walk_line(i, j, di, 0, ti, tj) || walk_line(i, j, 0, dj, ti, tj)) return 1'b1;
      if (on_g(i + di, j + dj) && obst(i, j + dj) && obst(i + di, j)) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic stop_t predict_jump(int r, int c, logic [3:0] d);
    stop_t s;
    int di, dj, si, sj;
    bit f;
    di = 0;
    dj = 0;
    case (d)
      DIR_UP:         di = -1;
      DIR_UP_RIGHT:   begin di = -1; dj = 1; end
      DIR_RIGHT:      dj = 1;
      DIR_DOWN_RIGHT: begin di = 1; dj = 1; end
      DIR_DOWN:       di = 1;
      DIR_DOWN_LEFT:  begin di = 1; dj = -1; end
      DIR_LEFT:       dj = -1;
      DIR_UP_LEFT:    begin di = -1; dj = -1; end
      default: ;
    endcase
    si = r;
    sj = c;
    f = 1'b0;
    if (di != 0 && dj != 0) f = walk_diag(r, c, di, dj, si, sj);
    else if (di != 0 || dj != 0) f = walk_line(r, c, di, dj, si, sj);
    s.row = si[7:0];
    s.col = sj[7:0];
    s.found = f;
    return s;
  endfunction

  task automatic send_item(logic kind, logic [5:0] r, logic [5:0] c, logic [3:0] d, logic b);
    if ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, b, d, c, r};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (kind == KIND_WRITE) begin
      cells[r][c] = b;
    end else begin
      exp_ring[exp_wr] = predict_jump(int'(r), int'(c), d);
      exp_wr = exp_wr + 12'd1;
    end
  endtask

  task automatic query(int r, int c, logic [3:0] d);
    send_item(KIND_QUERY, r[5:0], c[5:0], d, 1'($urandom_range(1)));
  endtask

  task automatic put_cell(int r, int c, bit b);
    send_item(KIND_WRITE, r[5:0], c[5:0], 4'($urandom_range(15)), b);
  endtask

  // let the block finish everything in flight
  task automatic drain();
    in_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_ALLOW_SQUEEZE: squeeze_ok = v[0];
      REG_GRID_HEIGHT:   rows_cfg = int'(v);
      REG_GRID_WIDTH:    cols_cfg = int'(v);
      REG_GOAL_ROW:      goal_r = int'(v[5:0]);
      REG_GOAL_COL:      goal_c = int'(v[5:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(bit sq, int h, int w, int gr, int gc);
    drain();
    write_reg(REG_ALLOW_SQUEEZE, {6'd0, sq});
    write_reg(REG_GRID_HEIGHT, h[6:0]);
    write_reg(REG_GRID_WIDTH, w[6:0]);
    write_reg(REG_GOAL_ROW, gr[6:0]);
    write_reg(REG_GOAL_COL, gc[6:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    query(63, 63, DIR_STATIC);
    query(5, 7, DIR_BAD_LO);
    query(0, 0, DIR_BAD_HI);
    query(0, 5, DIR_LEFT);
    query(3, 3, DIR_UP_LEFT);
    query(63, 63, DIR_UP_LEFT);
  endtask

  task automatic test_obstacles_and_squeeze();
    set_config(1'b0, 8, 8, 63, 63);
    put_cell(3, 3, 1'b1);
    put_cell(60, 60, 1'b1);
    query(3, 0, DIR_RIGHT);
    query(2, 0, DIR_RIGHT);
    query(7, 0, DIR_UP_RIGHT);
    query(10, 10, DIR_LEFT);
    query(3, 3, DIR_UP);
    put_cell(1, 2, 1'b1);
    put_cell(2, 1, 1'b1);
    query(3, 0, DIR_UP_RIGHT);
    query(0, 0, DIR_DOWN_RIGHT);
    query(4, 4, DIR_UP_LEFT);
    set_config(1'b1, 8, 8, 63, 63);
    query(0, 0, DIR_DOWN_RIGHT);
    query(2, 0, DIR_RIGHT);
    query(5, 0, DIR_DOWN_LEFT);
    put_cell(3, 3, 1'b0);
    query(3, 0, DIR_RIGHT);
  endtask

  task automatic test_grid_limits();
    set_config(1'b0, 0, 0, 0, 0);
    query(0, 0, DIR_DOWN);
    set_config(1'b1, 127, 127, 63, 0);
    query(63, 5, DIR_LEFT);
    set_config(1'b0, 1, 64, 0, 40);
    query(0, 63, DIR_LEFT);
    query(0, 0, DIR_DOWN_RIGHT);
  endtask

  task automatic test_random();
    int h, w, hu, wu, n_items, sel, r, c;
    for (int p = 0; p < 46; p++) begin
      if (p < 15) begin snd_idle = 8; rcv_idle = 64; end
      else if (p < 30) begin snd_idle = 64; rcv_idle = 8; end
      else begin snd_idle = 0; rcv_idle = 0; end
      sel = $urandom_range(99);
      if (sel < 88) begin
        h = $urandom_range(2, 10);
        w = $urandom_range(2, 10);
      end else begin
        h = $urandom_range(1) ? $urandom_range(64, 127) : $urandom_range(0, 1);
        w = $urandom_range(1) ? $urandom_range(64, 127) : $urandom_range(0, 12);
      end
      hu = h > 64 ? 64 : (h == 0 ? 1 : h);
      wu = w > 64 ? 64 : (w == 0 ? 1 : w);
      set_config(1'($urandom_range(1)), h, w, $urandom_range(hu - 1), $urandom_range(wu - 1));
      n_items = (hu * wu > 200) ? 8 : 40;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(99) < 85) begin
          r = $urandom_range(hu - 1);
          c = $urandom_range(wu - 1);
        end else begin
          r = $urandom_range(63);
          c = $urandom_range(63);
        end
        if (k < n_items / 3 || $urandom_range(99) < 20) put_cell(r, c, $urandom_range(99) < 55);
        else if ($urandom_range(99) < 92) query(r, c, 4'($urandom_range(1, 8)));
        else query(r, c, 4'($urandom_range(15)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // transfers are sampled mid-cycle; the handshake completes at the next edge
  always @(negedge clk) begin
    stop_t want, got;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[15:8], out_tdata[16]};
        if (exp_wr == exp_rd) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = exp_ring[exp_rd];
          exp_rd = exp_rd + 12'd1;
          if (want.row !== got.row) begin
            $display("%0t stop_row: expected %h, actual %h", $time, want.row, got.row);
            errors++;
          end
          if (want.col !== got.col) begin
            $display("%0t stop_col: expected %h, actual %h", $time, want.col, got.col);
            errors++;
          end
          if (want.found !== got.found) begin
            $display("%0t found: expected %b, actual %b", $time, want.found, got.found);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    quiet_cycles = 0;
    exp_wr = '0;
    exp_rd = '0;
    snd_idle = 8;
    rcv_idle = 64;
    squeeze_ok = 1'b0;
    rows_cfg = 64;
    cols_cfg = 64;
    goal_r = 0;
    goal_c = 0;
    foreach (cells[i, j]) cells[i][j] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_obstacles_and_squeeze();
    test_grid_limits();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
